[rtl/core/crc_record_log_parser_top_macros.svh]
// Assertion macros shared by the record log parser modules.
`ifndef CRC_RECORD_LOG_PARSER_TOP_MACROS_SVH
`define CRC_RECORD_LOG_PARSER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CRLP_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CRLP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

[rtl/core/crlp_pkg.sv]
// Package with types, constants and the CRC function of the record log parser.
`timescale 1ns / 1ps
`default_nettype none
package crlp_pkg;
	localparam int HEADER_BYTES  = 32;
	localparam int FILEID_BYTES  = 8;
	localparam int OFFSET_BYTES  = 8;
	localparam int SIZE_BYTES    = 8;
	localparam int VERSION_BYTES = 8;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		REG_PUT = 3'd0, REG_DELETE = 3'd1, REG_BEGIN = 3'd2,
		REG_END = 3'd3, REG_MAGIC = 3'd4, REG_VERSION = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_NAME = 2'd0, KIND_REC = 2'd1, KIND_STOP = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STOP_CLEAN = 3'd0, STOP_TRUNC = 3'd1, STOP_CRC = 3'd2, STOP_TYPE = 3'd3,
		STOP_SHORT = 3'd4, STOP_MAGIC = 3'd5, STOP_VERSION = 3'd6
	} stop_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_final;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  rec_kind;
		logic [7:0]  name_byte;
		logic [31:0] name_length;
		logic [63:0] file_ident;
		logic [63:0] obj_offset;
		logic [63:0] obj_size;
		logic [63:0] obj_version;
		logic [7:0]  write_mode;
		logic [47:0] start_pos;
		logic [47:0] end_pos;
		logic [2:0]  stop_reason;
	} out_beat_t;

	typedef struct packed {
		logic [7:0]  put_code;
		logic [7:0]  delete_code;
		logic [7:0]  begin_code;
		logic [7:0]  end_code;
		logic [31:0] magic_word;
		logic [31:0] version_word;
	} cfg_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction
endpackage
`default_nettype wire

[rtl/core/crlp_front.sv]
// Front end: accepts input beats and the configuration writes, and queues input beats.
`timescale 1ns / 1ps
`default_nettype none
module crlp_front import crlp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_beat_t  in_data,
	input  wire logic      cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	output cfg_t           cfg,
	output logic           q_valid,
	input  wire logic      q_ready,
	output in_beat_t       q_data
);
	`include "crc_record_log_parser_top_macros.svh"
	in_beat_t        mem_q [QDEPTH];
	logic [QAW:0]    wp_q, rp_q;
	logic [QAW:0]    cnt;
	logic            push, pop;

	assign cnt      = wp_q - rp_q;
	assign in_ready = (cnt != QDEPTH[QAW:0]);
	assign q_valid  = (cnt != '0);
	assign q_data   = mem_q[rp_q[QAW-1:0]];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q[QAW-1:0]] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cfg  <= '{put_code: 8'd0, delete_code: 8'd1, begin_code: 8'd2,
				end_code: 8'd3, magic_word: 32'd0, version_word: 32'd1};
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PUT:     cfg.put_code     <= cfg_wdata[7:0];
					REG_DELETE:  cfg.delete_code  <= cfg_wdata[7:0];
					REG_BEGIN:   cfg.begin_code   <= cfg_wdata[7:0];
					REG_END:     cfg.end_code     <= cfg_wdata[7:0];
					REG_MAGIC:   cfg.magic_word   <= cfg_wdata;
					REG_VERSION: cfg.version_word <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	`CRLP_ASSERT_IMP(a_no_overflow, clk, arst_n, push, cnt != QDEPTH[QAW:0])
	`CRLP_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt == $past(cnt) + 1'b1)
	`CRLP_ASSERT_NEXT(a_cnt_dn, clk, arst_n, pop && !push, cnt == $past(cnt) - 1'b1)
endmodule
`default_nettype wire

[rtl/core/crlp_back.sv]
// Back end: the byte-wise parser, CRC check and the two-entry result buffer.
`timescale 1ns / 1ps
`default_nettype none
module crlp_back import crlp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      q_valid,
	output logic           q_ready,
	input  wire in_beat_t  q_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_beat_t      out_data
);
	`include "crc_record_log_parser_top_macros.svh"
	typedef enum logic [3:0] {
		PH_HDR, PH_TYPE, PH_NAME, PH_LEN, PH_FID, PH_OFF, PH_SIZE, PH_VER,
		PH_MODE, PH_CRC, PH_ABSORB
	} phase_t;

	phase_t      phase_q, ph_n;
	logic [47:0] pos_q, pos_n;
	logic [31:0] fcnt_q, fcnt_n;
	logic [63:0] fsh_q, fsh_n;
	logic [31:0] crc_q, crc_n;
	logic [47:0] rstart_q, rstart_n, vlen_q, vlen_n;
	logic [31:0] h_len_q, h_len_n;
	logic [63:0] h_fid_q, h_fid_n, h_off_q, h_off_n, h_size_q, h_size_n, h_ver_q, h_ver_n;
	logic [7:0]  h_mode_q, h_mode_n;
	logic [31:0] h_magic_q, h_magic_n, h_vers_q, h_vers_n;
	logic [2:0]  fail_q, fail_n;
	logic [1:0]  ck_q, ck_n;

	out_beat_t   buf_q [2];
	logic [1:0]  bcnt_q;
	logic        rp_q;
	out_beat_t   r0, r1;
	logic [1:0]  nres;
	logic        step, pop;
	logic [7:0]  b;
	logic [31:0] crc_b;
	logic [31:0] width;
	logic [31:0] fc1;
	phase_t      after_nm;
	logic        keep;

	assign b        = q_data.in_byte;
	assign crc_b    = crc_byte(crc_q, b);
	assign pop      = out_valid && out_ready;
	// A beat is taken only if both possible results fit in the buffer.
	assign q_ready  = (bcnt_q == 2'd0) || ((bcnt_q == 2'd1) && pop);
	assign step     = q_valid && q_ready;
	assign out_valid = (bcnt_q != 2'd0);
	assign out_data = buf_q[rp_q];
	assign fc1      = fcnt_q + 32'd1;

	always_comb begin
		unique case (ck_q)
			2'd0:    after_nm = PH_FID;
			2'd1:    after_nm = PH_VER;
			default: after_nm = PH_CRC;
		endcase
		unique case (phase_q)
			PH_FID:  width = FILEID_BYTES;
			PH_OFF:  width = OFFSET_BYTES;
			PH_SIZE: width = SIZE_BYTES;
			PH_VER:  width = VERSION_BYTES;
			PH_MODE: width = 32'd1;
			default: width = 32'd4;
		endcase
	end

	always_comb begin
		logic [2:0] reason;
		logic [63:0] fsh_new;
		ph_n = phase_q; pos_n = pos_q + 48'd1; fcnt_n = fcnt_q; fsh_n = fsh_q;
		crc_n = crc_q; rstart_n = rstart_q; vlen_n = vlen_q;
		h_len_n = h_len_q; h_fid_n = h_fid_q; h_off_n = h_off_q; h_size_n = h_size_q;
		h_ver_n = h_ver_q; h_mode_n = h_mode_q; h_magic_n = h_magic_q; h_vers_n = h_vers_q;
		fail_n = fail_q; ck_n = ck_q; keep = 1'b0;
		r0 = '0; r1 = '0; nres = 2'd0; reason = STOP_CLEAN;
		fsh_new = fsh_q | ({56'd0, b} << {fcnt_q[2:0], 3'b000});
		unique case (phase_q)
			PH_HDR: begin
				if (pos_q < 48'd4)
					h_magic_n = h_magic_q | ({24'd0, b} << {pos_q[1:0], 3'b000});
				else if (pos_q < 48'd8)
					h_vers_n = h_vers_q | ({24'd0, b} << {pos_q[1:0], 3'b000});
				if (pos_q == 48'(HEADER_BYTES - 1)) begin
					if (h_magic_n != cfg.magic_word) begin
						fail_n = STOP_MAGIC; ph_n = PH_ABSORB;
					end else if (h_vers_n != cfg.version_word) begin
						fail_n = STOP_VERSION; ph_n = PH_ABSORB;
					end else ph_n = PH_TYPE;
					h_magic_n = '0; h_vers_n = '0;
				end
			end
			PH_TYPE: begin
				keep = 1'b1;
				if (b == cfg.put_code) ck_n = 2'd0;
				else if (b == cfg.delete_code) ck_n = 2'd1;
				else if (b == cfg.begin_code) ck_n = 2'd2;
				else if (b == cfg.end_code) ck_n = 2'd3;
				else keep = 1'b0;
				if (!keep) begin
					fail_n = STOP_TYPE; ph_n = PH_ABSORB;
				end else begin
					rstart_n = pos_q;
					crc_n = crc_byte(32'd0, b);
					h_len_n = '0; h_fid_n = '0; h_off_n = '0; h_size_n = '0;
					h_ver_n = '0; h_mode_n = '0;
					fcnt_n = '0; fsh_n = '0; ph_n = PH_LEN;
				end
			end
			PH_NAME: begin
				crc_n = crc_b;
				r0.kind = KIND_NAME; r0.rec_kind = ck_q; r0.name_byte = b;
				r0.name_length = h_len_q; r0.start_pos = rstart_q;
				nres = 2'd1;
				fcnt_n = fcnt_q - 32'd1;
				if (fcnt_q == 32'd1) ph_n = after_nm;
			end
			PH_LEN, PH_FID, PH_OFF, PH_SIZE, PH_VER, PH_MODE: begin
				crc_n = crc_b;
				fsh_n = fsh_new;
				fcnt_n = fc1;
				if (fc1 >= width) begin
					fsh_n = '0; fcnt_n = '0;
					unique case (phase_q)
						PH_LEN: begin
							h_len_n = fsh_new[31:0];
							if (fsh_new[31:0] != 32'd0) begin
								ph_n = PH_NAME; fcnt_n = fsh_new[31:0];
							end else ph_n = after_nm;
						end
						PH_FID:  begin h_fid_n = fsh_new; ph_n = PH_OFF; end
						PH_OFF:  begin h_off_n = fsh_new; ph_n = PH_SIZE; end
						PH_SIZE: begin h_size_n = fsh_new; ph_n = PH_VER; end
						PH_VER:  begin
							h_ver_n = fsh_new;
							ph_n = (ck_q == 2'd0) ? PH_MODE : PH_CRC;
						end
						default: begin h_mode_n = fsh_new[7:0]; ph_n = PH_CRC; end
					endcase
				end
			end
			PH_CRC: begin
				fsh_n = fsh_q | ({56'd0, b} << {fcnt_q[1:0], 3'b000});
				fcnt_n = fc1;
				if (fc1 >= 32'd4) begin
					if (fsh_n[31:0] != crc_q) begin
						fail_n = STOP_CRC; ph_n = PH_ABSORB;
					end else begin
						r0.kind = KIND_REC; r0.rec_kind = ck_q;
						r0.name_length = h_len_q; r0.file_ident = h_fid_q;
						r0.obj_offset = h_off_q; r0.obj_size = h_size_q;
						r0.obj_version = h_ver_q; r0.write_mode = h_mode_q;
						r0.start_pos = rstart_q; r0.end_pos = pos_n;
						nres = 2'd1; vlen_n = pos_n; ph_n = PH_TYPE;
					end
					fsh_n = '0; fcnt_n = '0;
				end
			end
			default: ;
		endcase
		if (q_data.is_final) begin
			priority if (fail_n != STOP_CLEAN) reason = fail_n;
			else if (ph_n == PH_TYPE) reason = STOP_CLEAN;
			else if (ph_n == PH_HDR) reason = STOP_SHORT;
			else reason = STOP_TRUNC;
			r1 = '0; r1.kind = KIND_STOP; r1.stop_reason = reason;
			r1.end_pos = (reason >= STOP_SHORT) ? 48'd0 : vlen_n;
			if (nres == 2'd0) r0 = r1;
			nres = nres + 2'd1;
			ph_n = PH_HDR; pos_n = '0; fcnt_n = '0; fsh_n = '0; crc_n = '0;
			rstart_n = 48'(HEADER_BYTES); vlen_n = 48'(HEADER_BYTES);
			h_len_n = '0; h_fid_n = '0; h_off_n = '0; h_size_n = '0; h_ver_n = '0;
			h_mode_n = '0; h_magic_n = '0; h_vers_n = '0; fail_n = STOP_CLEAN; ck_n = '0;
		end
	end

	// Result buffer: two entries, written in order starting at the slot that is read next.
	always_ff @(posedge clk) begin
		if (step && nres != 2'd0) begin
			if (bcnt_q == 2'd1 && pop) begin
				buf_q[~rp_q] <= r0;
				buf_q[rp_q]  <= r1;
			end else begin
				buf_q[rp_q]  <= r0;
				buf_q[~rp_q] <= r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= '0; rp_q <= 1'b0;
			phase_q <= PH_HDR; pos_q <= '0; fcnt_q <= '0; fsh_q <= '0; crc_q <= '0;
			rstart_q <= 48'(HEADER_BYTES); vlen_q <= 48'(HEADER_BYTES);
			h_len_q <= '0; h_fid_q <= '0; h_off_q <= '0; h_size_q <= '0; h_ver_q <= '0;
			h_mode_q <= '0; h_magic_q <= '0; h_vers_q <= '0; fail_q <= '0; ck_q <= '0;
		end else begin
			if (pop) rp_q <= ~rp_q;
			bcnt_q <= bcnt_q - {1'b0, pop} + (step ? nres : 2'd0);
			if (step) begin
				phase_q <= ph_n; pos_q <= pos_n; fcnt_q <= fcnt_n; fsh_q <= fsh_n;
				crc_q <= crc_n; rstart_q <= rstart_n; vlen_q <= vlen_n;
				h_len_q <= h_len_n; h_fid_q <= h_fid_n; h_off_q <= h_off_n;
				h_size_q <= h_size_n; h_ver_q <= h_ver_n; h_mode_q <= h_mode_n;
				h_magic_q <= h_magic_n; h_vers_q <= h_vers_n; fail_q <= fail_n;
				ck_q <= ck_n;
			end
		end
	end

	`CRLP_ASSERT_IMP(a_buf_bound, clk, arst_n, 1'b1, bcnt_q <= 2'd2)
	`CRLP_ASSERT_IMP(a_absorb_fail, clk, arst_n, phase_q == PH_ABSORB, fail_q != STOP_CLEAN)
	`CRLP_ASSERT_NEXT(a_final_resets, clk, arst_n, step && q_data.is_final,
		phase_q == PH_HDR && pos_q == 48'd0)
endmodule
`default_nettype wire

[rtl/core/crc_record_log_parser_top.sv]
// Top level of the CRC-checked log record parser.
//
// Channel  | Handshake                 | Payload
// input    | in_valid / in_ready       | in_data  (in_byte, is_final)
// output   | out_valid / out_ready     | out_data (one result beat)
// config   | cfg_we                    | cfg_index, cfg_wdata
//
// One input beat is parsed per cycle while the result buffer has room; a beat may follow in the next cycle.
// The front queue (four beats) decouples input from the parser, so that the
// input keeps being taken while the parser waits on the output side, until the queue is full.
// The parser takes a beat when its two-entry result buffer has room for the up to
// two results that beat can cause, so one result per cycle sets the sustained rate.
// Reset is asynchronous and active low; it returns parser state and registers.
`timescale 1ns / 1ps
`default_nettype none
module crc_record_log_parser_top import crlp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_beat_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_beat_t        out_data,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	cfg_t     cfg;
	logic     q_valid, q_ready;
	in_beat_t q_data;

	// The front end holds configuration registers and the input queue.
	crlp_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.cfg_we, .cfg_index, .cfg_wdata, .cfg,
		.q_valid, .q_ready, .q_data
	);

	// The back end parses bytes and buffers results.
	crlp_back u_back (
		.clk, .arst_n, .cfg, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .out_data
	);
endmodule
`default_nettype wire
